/* rtl/core/a2s_pkg.sv */
// ----------------------------------------------------------------------------
// a2s_pkg
// Shared types and constants of the info reply validator.
// ----------------------------------------------------------------------------
package a2s_pkg;

	// configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic REG_MAX_BYTES = 1'b0;   // register index taken from paddr[2]
	localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

	// byte counter saturation
	localparam logic [15:0] CNT_SAT = 16'hFFFF;

	// defaults for top level parameters
	localparam int unsigned STRING_LIMIT_DEF = 256;
	localparam int unsigned IN_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 2;

	// byte values
	localparam logic [7:0] HDR_FF = 8'hFF;
	localparam logic [7:0] HDR_TAG = 8'h49;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_P = 8'h70;
	localparam logic [7:0] CH_W = 8'h77;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_O = 8'h6F;
	localparam logic [7:0] FLAG_MASK = 8'hF1;
	localparam logic [15:0] APP_EXTRA_ID = 16'd2400;

	// classified input byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_ff;
		logic       is_tag;
		logic       is_zero;
		logic       is_type;
		logic       is_env;
		logic       is_bool;
		logic       flag_ok;
	} cls_t;

	// verdict of one packet
	typedef struct packed {
		logic        valid;
		logic [15:0] length;
	} res_t;

endpackage

/* rtl/core/a2s_fifo.sv */
// ----------------------------------------------------------------------------
// a2s_fifo
// Small flop-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module a2s_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/a2s_classify.sv */
// ----------------------------------------------------------------------------
// a2s_classify
// Front end: tags each incoming byte with the value tests the parser needs.
// ----------------------------------------------------------------------------
module a2s_classify (
	input  logic           [7:0] data_byte,
	input  logic                 last_byte,
	output a2s_pkg::cls_t        cls
);

	always_comb begin
		cls.data    = data_byte;
		cls.last    = last_byte;
		cls.is_ff   = (data_byte == a2s_pkg::HDR_FF);
		cls.is_tag  = (data_byte == a2s_pkg::HDR_TAG);
		cls.is_zero = (data_byte == 8'h00);
		cls.is_type = data_byte inside {a2s_pkg::CH_D, a2s_pkg::CH_L, a2s_pkg::CH_P};
		cls.is_env  = data_byte inside {a2s_pkg::CH_L, a2s_pkg::CH_W, a2s_pkg::CH_M,
			a2s_pkg::CH_O};
		cls.is_bool = (data_byte[7:1] == 7'd0);
		// only bits of the allowed flag set may be present
		cls.flag_ok = ((data_byte & ~a2s_pkg::FLAG_MASK) == 8'h00);
	end

endmodule

/* rtl/core/a2s_parse.sv */
// ----------------------------------------------------------------------------
// a2s_parse
// Back end: walks the reply structure one classified byte per cycle (last byte
// held while out_full) and issues a verdict on the last byte of each packet.
// ----------------------------------------------------------------------------
module a2s_parse #(
	parameter int unsigned STRING_LIMIT = a2s_pkg::STRING_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          max_bytes,
	input  logic                 in_valid,
	input  a2s_pkg::cls_t        in_cls,
	output logic                 in_take,
	input  logic                 out_full,
	output logic                 out_push,
	output a2s_pkg::res_t        out_res
);

	localparam int unsigned SCW = $clog2(STRING_LIMIT + 1);

	typedef enum logic [12:0] {
		PH_HDR   = 13'b0000000000001,
		PH_STR   = 13'b0000000000010,
		PH_FIX   = 13'b0000000000100,
		PH_APP   = 13'b0000000001000,
		PH_VER   = 13'b0000000010000,
		PH_FLAG  = 13'b0000000100000,
		PH_PORT  = 13'b0000001000000,
		PH_SID   = 13'b0000010000000,
		PH_SPORT = 13'b0000100000000,
		PH_SPSTR = 13'b0001000000000,
		PH_KEY   = 13'b0010000000000,
		PH_GID   = 13'b0100000000000,
		PH_DONE  = 13'b1000000000000
	} phase_t;

	phase_t         phase_q, phase_nx;
	logic [15:0]    cnt_q, cnt_nx;
	logic [3:0]     idx_q, idx_nx;
	logic [1:0]     str_num_q, str_num_nx;
	logic [SCW-1:0] scnt_q, scnt_nx;
	logic [7:0]     app_lo_q, app_lo_nx;
	logic [7:0]     flags_q, flags_nx;
	logic           failed_q, failed_nx;
	logic           app_extra_q, app_extra_nx;

	logic           bad;
	logic           str_bad;
	logic [SCW-1:0] scnt_step;
	logic [3:0]     idx_inc;
	logic           ok;

	// next optional field after 'from' whose flag bit is set
	function automatic phase_t next_opt(input phase_t from, input logic [7:0] f);
		logic a_flag, a_port, a_sid, a_sport, a_spstr, a_key;
		phase_t r;
		a_flag  = (from == PH_FLAG);
		a_port  = a_flag  | (from == PH_PORT);
		a_sid   = a_port  | (from == PH_SID);
		a_sport = a_sid   | (from == PH_SPORT);
		a_spstr = a_sport | (from == PH_SPSTR);
		a_key   = a_spstr | (from == PH_KEY);
		if (a_flag && f[7]) begin
			r = PH_PORT;
		end else if (a_port && f[4]) begin
			r = PH_SID;
		end else if (a_sid && f[6]) begin
			r = PH_SPORT;
		end else if (a_sport && f[6]) begin
			r = PH_SPSTR;
		end else if (a_spstr && f[5]) begin
			r = PH_KEY;
		end else if (a_key && f[0]) begin
			r = PH_GID;
		end else begin
			r = PH_DONE;
		end
		return r;
	endfunction

	assign in_take = in_valid & (~in_cls.last | ~out_full);

	always_comb begin
		cnt_nx = (cnt_q != a2s_pkg::CNT_SAT) ? cnt_q + 16'd1 : cnt_q;

		// string terminator resets the count, overlong string fails
		str_bad   = ~in_cls.is_zero &
			(({1'b0, scnt_q} + (SCW + 1)'(1)) >= (SCW + 1)'(STRING_LIMIT));
		scnt_step = in_cls.is_zero ? '0 : scnt_q + SCW'(1);
		idx_inc   = idx_q + 4'd1;

		phase_nx     = phase_q;
		idx_nx       = idx_q;
		str_num_nx   = str_num_q;
		scnt_nx      = scnt_q;
		app_lo_nx    = app_lo_q;
		flags_nx     = flags_q;
		app_extra_nx = app_extra_q;
		bad          = 1'b0;

		case (phase_q)
			PH_HDR: begin
				if (idx_q < 4'd4) begin
					bad = ~in_cls.is_ff;
				end else if (idx_q == 4'd4) begin
					bad = ~in_cls.is_tag;
				end
				if (idx_inc >= 4'd6) begin
					idx_nx     = '0;
					phase_nx   = PH_STR;
					str_num_nx = '0;
				end else begin
					idx_nx = idx_inc;
				end
			end
			PH_STR: begin
				bad     = str_bad;
				scnt_nx = scnt_step;
				if (in_cls.is_zero) begin
					str_num_nx = str_num_q + 2'd1;
					if (str_num_q == 2'd3) begin
						phase_nx = PH_FIX;
					end
				end
			end
			PH_FIX: begin
				if (idx_q == 4'd0) begin
					app_lo_nx = in_cls.data;
				end else if (idx_q == 4'd1) begin
					app_extra_nx = ({in_cls.data, app_lo_q} == a2s_pkg::APP_EXTRA_ID);
				end else if (idx_q == 4'd5) begin
					bad = ~in_cls.is_type;
				end else if (idx_q == 4'd6) begin
					bad = ~in_cls.is_env;
				end else if (idx_q >= 4'd7) begin
					bad = ~in_cls.is_bool;
				end
				if (idx_inc >= 4'd9) begin
					idx_nx   = '0;
					phase_nx = app_extra_q ? PH_APP : PH_VER;
				end else begin
					idx_nx = idx_inc;
				end
			end
			PH_APP: begin
				if (idx_inc >= 4'd3) begin
					idx_nx   = '0;
					phase_nx = PH_VER;
				end else begin
					idx_nx = idx_inc;
				end
			end
			PH_VER: begin
				bad     = str_bad;
				scnt_nx = scnt_step;
				if (in_cls.is_zero) begin
					phase_nx = PH_FLAG;
				end
			end
			PH_FLAG: begin
				bad      = ~in_cls.flag_ok;
				flags_nx = in_cls.data;
				phase_nx = next_opt(PH_FLAG, in_cls.data);
			end
			PH_PORT, PH_SPORT: begin
				if (idx_inc >= 4'd2) begin
					idx_nx   = '0;
					phase_nx = next_opt(phase_q, flags_q);
				end else begin
					idx_nx = idx_inc;
				end
			end
			PH_SID, PH_GID: begin
				if (idx_inc >= 4'd8) begin
					idx_nx   = '0;
					phase_nx = next_opt(phase_q, flags_q);
				end else begin
					idx_nx = idx_inc;
				end
			end
			PH_SPSTR, PH_KEY: begin
				bad     = str_bad;
				scnt_nx = scnt_step;
				if (in_cls.is_zero) begin
					phase_nx = next_opt(phase_q, flags_q);
				end
			end
			default: begin
				// anything past the end of the structure
				bad = 1'b1;
			end
		endcase

		// once failed, or over the length limit, bytes are only counted
		if (failed_q || (cnt_nx > max_bytes)) begin
			failed_nx    = 1'b1;
			phase_nx     = phase_q;
			idx_nx       = idx_q;
			str_num_nx   = str_num_q;
			scnt_nx      = scnt_q;
			app_lo_nx    = app_lo_q;
			flags_nx     = flags_q;
			app_extra_nx = app_extra_q;
		end else begin
			failed_nx = bad;
		end

		ok = ~failed_nx & ((phase_nx == PH_FLAG) | (phase_nx == PH_DONE));
	end

	assign out_push       = in_take & in_cls.last;
	assign out_res.valid  = ok;
	assign out_res.length = cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			cnt_q       <= '0;
			idx_q       <= '0;
			str_num_q   <= '0;
			scnt_q      <= '0;
			app_lo_q    <= '0;
			flags_q     <= '0;
			failed_q    <= 1'b0;
			app_extra_q <= 1'b0;
		end else if (in_take) begin
			if (in_cls.last) begin
				phase_q     <= PH_HDR;
				cnt_q       <= '0;
				idx_q       <= '0;
				str_num_q   <= '0;
				scnt_q      <= '0;
				app_lo_q    <= '0;
				flags_q     <= '0;
				failed_q    <= 1'b0;
				app_extra_q <= 1'b0;
			end else begin
				phase_q     <= phase_nx;
				cnt_q       <= cnt_nx;
				idx_q       <= idx_nx;
				str_num_q   <= str_num_nx;
				scnt_q      <= scnt_nx;
				app_lo_q    <= app_lo_nx;
				flags_q     <= flags_nx;
				failed_q    <= failed_nx;
				app_extra_q <= app_extra_nx;
			end
		end
	end

endmodule

/* rtl/core/a2s_info_reply_validator.sv */
// ----------------------------------------------------------------------------
// a2s_info_reply_validator
// Checks a game-server info reply byte by byte and gives one verdict per
// packet on its last byte.
//
// channel   dir  handshake          payload
// bytes     in   push / full        data_byte[7:0], last_byte
// verdicts  out  pop / empty        packet_valid, packet_length[15:0]
// config    in   apb psel/penable   max_packet_bytes at byte address 0
//
// one byte per cycle sustained while the verdict queue has room; a byte is
// stored in the front queue and parsed by the back end in the cycle it leaves
// it, and its verdict is registered in the verdict queue before the result ports.
// the back end holds a last byte while the verdict queue is full, and full
// rises once the byte queue fills behind it.
// reset clears the queues and the parser; max_packet_bytes returns to 4096.
// ----------------------------------------------------------------------------
module a2s_info_reply_validator #(
	parameter int unsigned STRING_LIMIT = a2s_pkg::STRING_LIMIT_DEF,
	parameter int unsigned IN_DEPTH     = a2s_pkg::IN_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH    = a2s_pkg::OUT_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte requests
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	// verdicts
	output logic                        empty,
	input  logic                        pop,
	output logic                        packet_valid,
	output logic [15:0]                 packet_length,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [a2s_pkg::APB_AW-1:0]  paddr,
	input  logic [a2s_pkg::APB_DW-1:0]  pwdata,
	output logic [a2s_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int unsigned CLS_W = $bits(a2s_pkg::cls_t);
	localparam int unsigned RES_W = $bits(a2s_pkg::res_t);

	logic [15:0]       max_bytes_q;
	a2s_pkg::cls_t     cls_front;
	a2s_pkg::cls_t     cls_back;
	logic [CLS_W-1:0]  cls_rd;
	logic              cls_empty;
	logic              cls_take;
	logic              res_full;
	logic              res_push;
	a2s_pkg::res_t     res_wr;
	logic [RES_W-1:0]  res_rd;
	a2s_pkg::res_t     res_head;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == a2s_pkg::REG_MAX_BYTES) ?
		{{(a2s_pkg::APB_DW - 16){1'b0}}, max_bytes_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= a2s_pkg::MAX_BYTES_RST;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == a2s_pkg::REG_MAX_BYTES)) begin
			max_bytes_q <= pwdata[15:0];
		end
	end

	a2s_classify u_classify (
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cls       (cls_front)
	);

	a2s_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (IN_DEPTH)
	) u_byte_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_front),
		.full   (full),
		.pop    (cls_take),
		.rdata  (cls_rd),
		.empty  (cls_empty)
	);

	assign cls_back = a2s_pkg::cls_t'(cls_rd);

	a2s_parse #(
		.STRING_LIMIT (STRING_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_bytes (max_bytes_q),
		.in_valid  (~cls_empty),
		.in_cls    (cls_back),
		.in_take   (cls_take),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_res   (res_wr)
	);

	a2s_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_verdict_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd),
		.empty  (empty)
	);

	assign res_head      = a2s_pkg::res_t'(res_rd);
	assign packet_valid  = res_head.valid;
	assign packet_length = res_head.length;

endmodule
